>>> rtl/core/i2cm_pkg.sv
package i2cm_pkg;

    localparam int DATA_BITS   = 8;
    localparam int TICKS_W     = 16;
    localparam int BIT_CNT_W   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;

    localparam logic [TICKS_W-1:0] RESET_PHASE_TICKS = TICKS_W'(100);

    // Bit counter values that mark the acknowledge bit and the trailing delay.
    localparam logic [BIT_CNT_W-1:0] BIT_ACK   = BIT_CNT_W'(DATA_BITS);
    localparam logic [BIT_CNT_W-1:0] BIT_TRAIL = BIT_CNT_W'(DATA_BITS + 1);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // One tick of bus activity as carried through the queue.
    typedef struct packed {
        logic                cmd_valid;
        t_op                 command;
        logic [7:0]          write_data;
        logic                ack_to_send;
        logic                sda_in;
    } t_item;

    // Result fields, packed so that scl_out lands in bit 0.
    typedef struct packed {
        logic                ack_received;
        logic [7:0]          read_data;
        logic                done_res;
        logic                busy_res;
        logic                sda_out;
        logic                scl_out;
    } t_result;

    typedef struct packed {
        logic                full;
        logic                empty;
    } t_queue_status;

endpackage

>>> rtl/core/i2cm_front.sv
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  t_queue_status        i_queue,
    output logic                 o_push,
    output t_item                o_item
);

    logic  r_valid;
    t_item r_item;
    t_item w_item;

    // Unpack the transaction into the queue entry format.
    always_comb begin
        w_item.cmd_valid   = s_axis_tuser[0];
        w_item.command     = t_op'(s_axis_tuser[2:1]);
        w_item.write_data  = s_axis_tdata[7:0];
        w_item.ack_to_send = s_axis_tdata[8];
        w_item.sda_in      = s_axis_tdata[9];
    end

    assign s_axis_tready = !r_valid || !i_queue.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_item <= w_item;
        end
    end

    assign o_push = r_valid && !i_queue.full;
    assign o_item = r_item;

endmodule

>>> rtl/core/i2cm_fifo.sv
module i2cm_fifo
    import i2cm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_status.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from an empty queue");

endmodule

>>> rtl/core/i2cm_engine.sv
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TICKS_W-1:0]    i_cfg_wdata,
    input  t_item                 i_item,
    input  t_queue_status         i_queue,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [TICKS_W-1:0]   r_phase_ticks;
    t_op                  r_op,       n_op;
    logic                 r_active,   n_active;
    logic [1:0]           r_phase,    n_phase;
    logic [BIT_CNT_W-1:0] r_bit,      n_bit;
    logic [7:0]           r_shift,    n_shift;
    logic [TICKS_W-1:0]   r_ticks,    n_ticks;
    logic                 r_scl,      n_scl;
    logic                 r_sda,      n_sda;
    logic                 r_ack_latch, n_ack_latch;
    logic                 r_ack_drive, n_ack_drive;
    logic [7:0]           r_read_hold, n_read_hold;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_enter;
    logic                 w_done;
    logic [1:0]           w_last_phase;
    logic [BIT_CNT_W-1:0] w_last_bit;
    logic [TICKS_W-1:0]   w_ticks_dec;
    t_result              w_result;

    assign o_pop = !i_queue.empty && (!r_out_valid || m_axis_tready);

    // Last phase index of the current bit and last bit index of the command.
    always_comb begin
        case (r_op)
            OP_WRITE: begin
                if (r_bit < BIT_ACK) begin
                    w_last_phase = 2'd2;
                end else if (r_bit == BIT_ACK) begin
                    w_last_phase = 2'd3;
                end else begin
                    w_last_phase = 2'd0;
                end
                w_last_bit = BIT_TRAIL;
            end
            OP_READ: begin
                w_last_phase = (r_bit < BIT_ACK) ? 2'd3 : 2'd2;
                w_last_bit   = BIT_ACK;
            end
            default: begin
                w_last_phase = 2'd2;
                w_last_bit   = '0;
            end
        endcase
    end

    assign w_ticks_dec = (r_ticks != '0) ? r_ticks - 1'b1 : '0;

    always_comb begin
        n_op        = r_op;
        n_active    = r_active;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_ticks     = r_ticks;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack_latch = r_ack_latch;
        n_ack_drive = r_ack_drive;
        n_read_hold = r_read_hold;
        w_enter     = 1'b0;
        w_done      = 1'b0;

        if (r_active) begin
            n_ticks = w_ticks_dec;
            if (w_ticks_dec == '0) begin
                if (r_phase < w_last_phase) begin
                    n_phase = r_phase + 1'b1;
                    w_enter = 1'b1;
                end else if (r_bit < w_last_bit) begin
                    n_bit   = r_bit + 1'b1;
                    n_phase = 2'd0;
                    w_enter = 1'b1;
                end else begin
                    n_active = 1'b0;
                    w_done   = 1'b1;
                    if (r_op == OP_READ) begin
                        n_read_hold = r_shift;
                    end
                end
            end
        end else if (i_item.cmd_valid) begin
            n_op     = i_item.command;
            n_active = 1'b1;
            n_bit    = '0;
            n_phase  = 2'd0;
            w_enter  = 1'b1;
            if (i_item.command == OP_WRITE) begin
                n_shift = i_item.write_data;
            end
            if (i_item.command == OP_READ) begin
                n_shift     = '0;
                n_ack_drive = i_item.ack_to_send;
            end
        end

        // Drive the bus lines for the phase just entered.
        if (w_enter) begin
            n_ticks = (r_phase_ticks == '0) ? TICKS_W'(1) : r_phase_ticks;
            case (n_op)
                OP_START: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b1;
                        n_scl = 1'b1;
                    end else if (n_phase == 2'd1) begin
                        n_sda = 1'b0;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
                OP_STOP: begin
                    if (n_phase == 2'd0) begin
                        n_sda = 1'b0;
                    end else if (n_phase == 2'd1) begin
                        n_scl = 1'b1;
                    end else begin
                        n_sda = 1'b1;
                    end
                end
                default: begin
                    if ((n_op == OP_WRITE && n_bit < BIT_ACK) ||
                        (n_op == OP_READ && n_bit == BIT_ACK)) begin
                        // Driven bit: a data bit of a write or the master's acknowledge.
                        if (n_phase == 2'd0) begin
                            if (n_op == OP_WRITE) begin
                                n_sda   = n_shift[7];
                                n_shift = {n_shift[6:0], 1'b0};
                            end else begin
                                n_sda = n_ack_drive;
                            end
                        end else if (n_phase == 2'd1) begin
                            n_scl = 1'b1;
                        end else begin
                            n_scl = 1'b0;
                        end
                    end else if (n_op == OP_WRITE && n_bit > BIT_ACK) begin
                        n_scl = r_scl;
                    end else begin
                        // Sampled bit: a data bit of a read or the slave's acknowledge.
                        if (n_phase == 2'd0) begin
                            n_sda = 1'b1;
                        end else if (n_phase == 2'd1) begin
                            n_scl = 1'b1;
                        end else if (n_phase == 2'd2) begin
                            if (n_op == OP_READ) begin
                                n_shift = {n_shift[6:0], i_item.sda_in};
                            end else begin
                                n_ack_latch = i_item.sda_in;
                            end
                        end else begin
                            n_scl = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        w_result.scl_out      = n_scl;
        w_result.sda_out      = n_sda;
        w_result.busy_res     = n_active;
        w_result.done_res     = w_done;
        w_result.read_data    = n_read_hold;
        w_result.ack_received = n_ack_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= RESET_PHASE_TICKS;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_START;
            r_active    <= 1'b0;
            r_phase     <= 2'd0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_ticks     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack_latch <= 1'b0;
            r_ack_drive <= 1'b1;
            r_read_hold <= '0;
        end else if (o_pop) begin
            r_op        <= n_op;
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_ticks     <= n_ticks;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack_latch <= n_ack_latch;
            r_ack_drive <= n_ack_drive;
            r_read_hold <= n_read_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

    a_start_stop_single_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && (r_op == OP_START || r_op == OP_STOP) |-> r_bit == '0)
        else $error("start or stop advanced past its only bit");

    a_bit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_bit <= BIT_TRAIL && (r_op == OP_WRITE || r_bit <= BIT_ACK))
        else $error("bit counter beyond last bit of command");

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_active && r_ticks > TICKS_W'(1) |=> $stable(r_phase) && $stable(r_bit))
        else $error("phase advanced before its delay expired");

endmodule

>>> rtl/core/i2c_master_byte_engine_core.sv
// I2C master bit engine. Every input transaction is one tick of the bus timebase and
// yields exactly one output transaction holding the line drives and status after it.
// Input tuser carries the command selector, tdata the byte, acknowledge and SDA sample.
// A command (start, stop, write byte, read byte) is taken only while the engine is not
// busy; each of its phases holds the lines for phase_ticks ticks (0 acts as 1).
// A write clocks eight bits out MSB first, then samples the slave acknowledge,
// then one delay phase follows. A read samples eight bits, then drives the acknowledge.
// Accepted transactions move through the input register and queue to the output register.
// Throughput: one transaction per cycle; the input register, a four-entry queue and the
// output register let either side stall independently, and the engine advances one tick
// per cycle whenever the queue is not empty and the output register is free or taken.
// When the receiver stalls, s_axis_tready drops once the queue is full and the input
// register holds a transaction, six transactions in flight counting the output register.
// Reset (i_rst_n low, synchronous) empties the pipeline, releases both lines, clears
// status and read data, and restores phase_ticks to 100.
// Configuration: i_cfg_we writes i_cfg_wdata into phase_ticks; write it only when idle.
module i2c_master_byte_engine_core
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TICKS_W-1:0]    i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] write_data, [8] ack_to_send, [9] sda_in, [15:10] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd_valid, [2:1] command
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_received, [15:13] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_queue_status w_queue;
    logic          w_push;
    logic          w_pop;
    t_item         w_front_item;
    t_item         w_queue_item;

    i2cm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_queue       (w_queue),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    i2cm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_front_item),
        .i_pop    (w_pop),
        .o_item   (w_queue_item),
        .o_status (w_queue)
    );

    i2cm_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (w_queue_item),
        .i_queue       (w_queue),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/i2c_master_byte_engine_core_test.sv
module i2c_master_byte_engine_core_test;
    import i2cm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_PRINTS  = 40;

    // Line and status values that can be read straight off the reset state.
    localparam t_result AT_RESET = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
                                     done_res: 1'b0, read_data: 8'h00, ack_received: 1'b0};
    localparam t_result START_TAKEN = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b1,
                                        done_res: 1'b0, read_data: 8'h00, ack_received: 1'b0};

    typedef struct {
        int         cfg;       // phase_ticks to write before the row, -1 keeps it
        bit         cv;
        t_op        cmd;
        logic [7:0] wd;
        bit         ack;
        bit         sda;
        bit         run_out;   // tick on with this sda level until the command ends
        bit         typed;
        t_result    want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [TICKS_W-1:0]    i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    i2c_master_byte_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predicted bus engine state.
    logic [TICKS_W-1:0]   phase_len = RESET_PHASE_TICKS;
    t_op                  eng_op = OP_START;
    logic                 eng_active = 1'b0;
    logic [1:0]           eng_phase = '0;
    logic [BIT_CNT_W-1:0] eng_bit = '0;
    logic [7:0]           eng_shift = '0;
    logic [TICKS_W-1:0]   eng_ticks = '0;
    logic                 eng_scl = 1'b1;
    logic                 eng_sda = 1'b1;
    logic                 eng_ack = 1'b0;
    logic                 eng_ack_drive = 1'b1;
    logic [7:0]           eng_rd = '0;

    t_result bus_state_q[$];
    int      mismatches = 0;
    int      cycle_cnt = 0;
    bit      tx_idle_on = 1'b1;
    bit      rx_idle_on = 1'b1;
    int      holds_asked = 0;
    int      holds_taken = 0;
    int      hold_left = 0;
    int      rx_stall_left = 0;
    bit      frame_open = 1'b0;
    int      frame_bytes = 0;
    t_result seen_res;
    t_result want_res;

    // Lines are set when a phase is entered and then held for phase_len ticks.
    function automatic void enter_bus_phase(logic sda_now);
        eng_ticks = (phase_len == '0) ? TICKS_W'(1) : phase_len;
        if (eng_op == OP_START) begin
            case (eng_phase)
                2'd0: begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end
                2'd1: eng_sda = 1'b0;
                default: eng_scl = 1'b0;
            endcase
        end else if (eng_op == OP_STOP) begin
            case (eng_phase)
                2'd0: eng_sda = 1'b0;
                2'd1: eng_scl = 1'b1;
                default: eng_sda = 1'b1;
            endcase
        end else if ((eng_op == OP_WRITE && eng_bit < BIT_ACK) ||
                     (eng_op == OP_READ && eng_bit == BIT_ACK)) begin
            // Bit driven by the master: a write data bit or the read acknowledge.
            if (eng_phase == 2'd0) begin
                if (eng_op == OP_WRITE) begin
                    eng_sda = eng_shift[7];
                    eng_shift = {eng_shift[6:0], 1'b0};
                end else begin
                    eng_sda = eng_ack_drive;
                end
            end else if (eng_phase == 2'd1) begin
                eng_scl = 1'b1;
            end else begin
                eng_scl = 1'b0;
            end
        end else if (!(eng_op == OP_WRITE && eng_bit > BIT_ACK)) begin
            // Bit driven by the slave; the trailing write delay changes nothing.
            case (eng_phase)
                2'd0: eng_sda = 1'b1;
                2'd1: eng_scl = 1'b1;
                2'd2: begin
                    if (eng_op == OP_READ)
                        eng_shift = {eng_shift[6:0], sda_now};
                    else
                        eng_ack = sda_now;
                end
                default: eng_scl = 1'b0;
            endcase
        end
    endfunction

    function automatic t_result engine_tick(t_item it);
        logic [1:0]           last_ph;
        logic [BIT_CNT_W-1:0] last_b;
        logic                 done;
        t_result              r;
        done = 1'b0;
        if (eng_active) begin
            if (eng_ticks != '0)
                eng_ticks = eng_ticks - 1'b1;
            if (eng_ticks == '0) begin
                case (eng_op)
                    OP_WRITE: begin
                        last_ph = (eng_bit < BIT_ACK) ? 2'd2 : (eng_bit == BIT_ACK) ? 2'd3 : 2'd0;
                        last_b = BIT_TRAIL;
                    end
                    OP_READ: begin
                        last_ph = (eng_bit < BIT_ACK) ? 2'd3 : 2'd2;
                        last_b = BIT_ACK;
                    end
                    default: begin
                        last_ph = 2'd2;
                        last_b = '0;
                    end
                endcase
                if (eng_phase < last_ph) begin
                    eng_phase = eng_phase + 1'b1;
                    enter_bus_phase(it.sda_in);
                end else if (eng_bit < last_b) begin
                    eng_bit = eng_bit + 1'b1;
                    eng_phase = '0;
                    enter_bus_phase(it.sda_in);
                end else begin
                    eng_active = 1'b0;
                    done = 1'b1;
                    if (eng_op == OP_READ)
                        eng_rd = eng_shift;
                end
            end
        end else if (it.cmd_valid) begin
            eng_op = it.command;
            eng_active = 1'b1;
            eng_bit = '0;
            eng_phase = '0;
            if (it.command == OP_WRITE)
                eng_shift = it.write_data;
            if (it.command == OP_READ) begin
                eng_shift = '0;
                eng_ack_drive = it.ack_to_send;
            end
            enter_bus_phase(it.sda_in);
        end
        r.scl_out = eng_scl;
        r.sda_out = eng_sda;
        r.busy_res = eng_active;
        r.done_res = done;
        r.read_data = eng_rd;
        r.ack_received = eng_ack;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_cnt);
    endtask

    // One bus tick per transaction; the expectation is queued when it is accepted.
    task automatic offer_tick(t_item it, bit typed = 1'b0, t_result want = '0);
        t_result predicted;
        if (tx_idle_on && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, it.sda_in, it.ack_to_send, it.write_data};
        s_axis_tuser <= {it.command, it.cmd_valid};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = engine_tick(it);
        bus_state_q.push_back(typed ? want : predicted);
    endtask

    function automatic t_item idle_tick(int sda);
        t_item it;
        it.cmd_valid = 1'b0;
        it.command = t_op'($urandom_range(0, 3));
        it.write_data = 8'($urandom_range(0, 255));
        it.ack_to_send = 1'($urandom_range(0, 1));
        it.sda_in = (sda < 0) ? 1'($urandom_range(0, 1)) : 1'(sda);
        return it;
    endfunction

    // Ticks with no command until the command in progress completes.
    task automatic finish_command(int sda);
        while (eng_active)
            offer_tick(idle_tick(sda));
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (bus_state_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_phase_ticks(int v);
        wait_results_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= TICKS_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phase_len = TICKS_W'(v);
    endtask

    // Mostly well formed frames: start, one to three bytes, stop. Some commands are
    // random, and commands offered while busy must be ignored.
    task automatic offer_bus_traffic();
        t_item it;
        it = idle_tick(-1);
        if (!eng_active) begin
            if ($urandom_range(0, 2) == 0) begin
                it.cmd_valid = 1'b1;
                if ($urandom_range(0, 9) != 0) begin
                    if (!frame_open) begin
                        it.command = OP_START;
                        frame_open = 1'b1;
                        frame_bytes = $urandom_range(1, 3);
                    end else if (frame_bytes > 0) begin
                        it.command = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                        frame_bytes--;
                    end else begin
                        it.command = OP_STOP;
                        frame_open = 1'b0;
                    end
                end
            end
        end else if ($urandom_range(0, 15) == 0) begin
            it.cmd_valid = 1'b1;
        end
        offer_tick(it);
    endtask

    t_dir_row dir_rows [0:13] = '{
        '{-1, 1'b0, OP_READ,  8'hA5, 1'b1, 1'b0, 1'b0, 1'b1, AT_RESET},
        '{-1, 1'b1, OP_START, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, START_TAKEN},
        // A command while busy is dropped.
        '{-1, 1'b1, OP_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, START_TAKEN},
        '{1,  1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_WRITE, 8'hA5, 1'b1, 1'b0, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_READ,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_READ,  8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_STOP,  8'h3C, 1'b0, 1'b1, 1'b1, 1'b0, AT_RESET},
        // Zero phase ticks behaves as one; a write with no start runs as given.
        '{0,  1'b1, OP_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_READ,  8'h81, 1'b0, 1'b1, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_STOP,  8'h00, 1'b1, 1'b0, 1'b1, 1'b0, AT_RESET},
        '{-1, 1'b1, OP_START, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, AT_RESET}
    };

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** i2c_master_byte_engine_core: FAILED **");
            $finish;
        end
    end

    // Receiver side: random stall bursts and, on request, one long hold-off.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_taken != holds_asked) begin
            holds_taken <= holds_taken + 1;
            hold_left <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            rx_stall_left <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_res = t_result'(m_axis_tdata[12:0]);
            if (bus_state_q.size() == 0) begin
                flag_mismatch("transaction with nothing expected", seen_res, 0);
            end else begin
                want_res = bus_state_q.pop_front();
                if (seen_res.scl_out != want_res.scl_out)
                    flag_mismatch("scl_out", seen_res.scl_out, want_res.scl_out);
                if (seen_res.sda_out != want_res.sda_out)
                    flag_mismatch("sda_out", seen_res.sda_out, want_res.sda_out);
                if (seen_res.busy_res != want_res.busy_res)
                    flag_mismatch("busy_res", seen_res.busy_res, want_res.busy_res);
                if (seen_res.done_res != want_res.done_res)
                    flag_mismatch("done_res", seen_res.done_res, want_res.done_res);
                if (seen_res.read_data != want_res.read_data)
                    flag_mismatch("read_data", seen_res.read_data, want_res.read_data);
                if (seen_res.ack_received != want_res.ack_received)
                    flag_mismatch("ack_received", seen_res.ack_received, want_res.ack_received);
            end
        end
    end

    initial begin
        t_item it;
        int    tick_settings [0:4];
        tick_settings = '{1, 0, 2, 3, $urandom_range(1, 5)};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg >= 0)
                set_phase_ticks(dir_rows[i].cfg);
            it.cmd_valid = dir_rows[i].cv;
            it.command = dir_rows[i].cmd;
            it.write_data = dir_rows[i].wd;
            it.ack_to_send = dir_rows[i].ack;
            it.sda_in = dir_rows[i].sda;
            offer_tick(it, dir_rows[i].typed, dir_rows[i].want);
            if (dir_rows[i].run_out)
                finish_command(dir_rows[i].sda);
        end

        for (int p = 0; p < 5; p++) begin
            set_phase_ticks(tick_settings[p]);
            tx_idle_on = (p < 3);
            rx_idle_on <= (p < 3);
            // Hold the output off long enough that the input side backs up.
            if (p == 2)
                holds_asked <= holds_asked + 1;
            repeat (24) offer_bus_traffic();
            finish_command(-1);
        end

        // Widest phase setting: only the start of a long phase can be seen.
        set_phase_ticks(16'hFFFF);
        it = idle_tick(-1);
        it.cmd_valid = 1'b1;
        it.command = OP_START;
        offer_tick(it);
        repeat (10) offer_tick(idle_tick(-1));

        wait_results_drained();
        if (mismatches == 0)
            $display("** i2c_master_byte_engine_core: PASSED **");
        else
            $display("** i2c_master_byte_engine_core: FAILED **");
        $finish;
    end

endmodule
